>>> rtl/psh_pkg.sv
// Shared types, constants and hash helpers for the prefix subtree hasher.
package psh_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // The FNV prime is 2^40 + 0x1b3, so a product is a shift plus a narrow multiply.
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam logic [63:0] GOLDEN       = 64'h9e3779b97f4a7c15;
    localparam logic signed [15:0] UNARY_FROM = 16'sd10;
    localparam logic [6:0]  SIZE_SAT     = 7'd127;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic [63:0] hash;
        logic [1:0]  kids;
        logic        new_expr;
        logic [15:0] expr_id;
        logic [5:0]  position;
    } t_job;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHILD,
        S_MIX,
        S_DONE
    } t_back_state;

    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        logic [63:0] lo;
        lo = h * {55'd0, FNV_PRIME_LO};
        return {h[23:0], 40'd0} + lo;
    endfunction

    function automatic logic [63:0] mix_child(input logic [63:0] h, input logic [63:0] c);
        return h ^ (c + GOLDEN + {h[57:0], 6'd0} + {2'd0, h[63:2]});
    endfunction

endpackage

>>> rtl/psh_front.sv
// Input stage: takes tokens, runs the two FNV-1a rounds and classifies the arity.
module psh_front
    import psh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_token_code,
    input  logic [63:0]        i_value_bits,
    input  logic [5:0]         i_position,
    input  logic [15:0]        i_expr_id,
    input  logic               i_new_expr,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output t_job               o_job
);

    logic        r_v1;
    logic [63:0] r_h1;
    logic [63:0] r_vbits1;
    logic [1:0]  r_kids1;
    logic        r_new1;
    logic [15:0] r_eid1;
    logic [5:0]  r_pos1;
    logic        r_v2;
    t_job        r_job;

    logic        take1;
    logic        take2;
    logic [63:0] n_h1;
    logic [1:0]  n_kids;

    assign take2 = !r_v2 || i_job_ready;
    assign take1 = !r_v1 || take2;
    assign o_ready = take1;
    assign o_job_valid = r_v2;
    assign o_job = r_job;

    always_comb begin
        n_h1 = fnv_mul(FNV_BASIS ^ {{48{i_token_code[15]}}, i_token_code});
        if (i_token_code > 16'sd0) begin
            n_kids = (i_token_code < UNARY_FROM) ? 2'd2 : 2'd1;
        end else begin
            n_kids = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_valid;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_h1     <= n_h1;
            r_vbits1 <= i_value_bits;
            r_kids1  <= n_kids;
            r_new1   <= i_new_expr;
            r_eid1   <= i_expr_id;
            r_pos1   <= i_position;
        end
        if (take2) begin
            r_job.hash     <= fnv_mul(r_h1 ^ r_vbits1);
            r_job.kids     <= r_kids1;
            r_job.new_expr <= r_new1;
            r_job.expr_id  <= r_eid1;
            r_job.position <= r_pos1;
        end
    end

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !i_job_ready) |=> r_v2)
        else $error("front stage two lost a stalled item");

endmodule

>>> rtl/psh_queue.sv
// Short FIFO of classified jobs between the hashing front and the stack engine.
module psh_queue
    import psh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(QDEPTH))
        else $error("job queue count out of range");

endmodule

>>> rtl/psh_back.sv
// Stack engine: pops children, folds their hashes and sizes, pushes the new subtree.
module psh_back
    import psh_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    input  logic [6:0]  i_min_size,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_expr_id,
    output logic [5:0]  o_out_position,
    output logic [6:0]  o_subtree_size,
    output logic [63:0] o_subtree_hash,
    output logic        o_is_candidate,
    output logic        o_overflow
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [6:0]  r_size_mem [MAX_LEN];
    logic [63:0] r_hash_mem [MAX_LEN];

    t_back_state r_state;
    t_back_state n_state;
    logic [CW-1:0] r_count;
    logic [1:0]    r_kids;
    logic [63:0]   r_hash;
    logic [7:0]    r_size;
    logic [15:0]   r_eid;
    logic [5:0]    r_pos;
    logic [6:0]    r_rd_size;
    logic [63:0]   r_rd_hash;
    logic          r_ov;
    logic [15:0]   r_o_eid;
    logic [5:0]    r_o_pos;
    logic [6:0]    r_o_size;
    logic [63:0]   r_o_hash;
    logic          r_o_cand;
    logic          r_o_over;

    logic          pop;
    logic          rd_en;
    logic          out_load;
    logic          room;
    logic [6:0]    fin_size;
    logic          fin_over;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign room     = (r_count < CW'(MAX_LEN));
    assign fin_size = (r_size > {1'b0, SIZE_SAT}) ? SIZE_SAT : r_size[6:0];
    assign fin_over = (int'(r_size) > MAX_LEN) || !room;
    assign rd_addr  = AW'(r_count - 1'b1);
    assign wr_addr  = AW'(r_count);
    assign o_job_ready = pop;

    always_comb begin
        n_state  = r_state;
        pop      = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    pop     = 1'b1;
                    n_state = S_CHILD;
                end
            end
            S_CHILD: begin
                if (r_kids != 2'd0 && r_count != '0) begin
                    rd_en   = 1'b1;
                    n_state = S_MIX;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MIX: begin
                n_state = S_CHILD;
            end
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && i_job.new_expr) begin
                r_count <= '0;
            end else if (rd_en) begin
                r_count <= r_count - 1'b1;
            end else if (out_load && room) begin
                r_count <= r_count + 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_hash <= i_job.hash;
            r_size <= 8'd1;
            r_kids <= i_job.kids;
            r_eid  <= i_job.expr_id;
            r_pos  <= i_job.position;
        end else if (rd_en) begin
            r_kids <= r_kids - 1'b1;
        end else if (r_state == S_MIX) begin
            r_hash <= mix_child(r_hash, r_rd_hash);
            r_size <= r_size + {1'b0, r_rd_size};
        end
        if (out_load) begin
            r_o_eid  <= r_eid;
            r_o_pos  <= r_pos;
            r_o_size <= fin_size;
            r_o_hash <= r_hash;
            r_o_cand <= (fin_size >= i_min_size);
            r_o_over <= fin_over;
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (out_load && room) begin
            r_size_mem[wr_addr] <= fin_size;
            r_hash_mem[wr_addr] <= r_hash;
        end
        r_rd_size <= r_size_mem[rd_addr];
        r_rd_hash <= r_hash_mem[rd_addr];
    end

    assign o_valid        = r_ov;
    assign o_out_expr_id  = r_o_eid;
    assign o_out_position = r_o_pos;
    assign o_subtree_size = r_o_size;
    assign o_subtree_hash = r_o_hash;
    assign o_is_candidate = r_o_cand;
    assign o_overflow     = r_o_over;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("stack count beyond depth");

    a_mix_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> ($past(r_state) == S_CHILD))
        else $error("child fold without a stack read");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_subtree_size != 7'd0))
        else $error("result with empty subtree");

endmodule

>>> rtl/prefix_subtree_hasher.sv
// Top level of the prefix subtree hasher: register port, front, queue and stack engine.
//
// Tokens of one prefix expression enter last token first on the input channel
// (i_valid / o_ready); new_expr marks the first token of an expression and
// empties the stack. Each item yields exactly one result on the output channel
// (o_valid / i_ready): expression number, start position, subtree size and
// hash, a candidate flag against the minimum size register, and an overflow flag.
// Front: two register stages run the two FNV-1a rounds, then a four-entry
// queue holds jobs for the stack engine. The engine takes one job at a time:
// S_IDLE pops it, each child costs a read of the stack memory in S_CHILD and
// a fold in S_MIX, and S_DONE loads the output register once that register is
// free. An accepted item passes front stage one, stage two, the queue, the
// engine and the output register, which drives o_valid. A finished result
// waits in an output register while the front keeps accepting items until the
// queue fills. When the receiver stalls, the engine holds its last result, then
// the queue and front fill and o_ready falls. Reset empties the stack, queue and
// pipeline and sets the minimum candidate size to 2; the stack memory itself is
// not cleared.
module prefix_subtree_hasher
    import psh_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_token_code,
    input  logic [63:0]        i_value_bits,
    input  logic [5:0]         i_position,
    input  logic [15:0]        i_expr_id,
    input  logic               i_new_expr,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_out_expr_id,
    output logic [5:0]         o_out_position,
    output logic [6:0]         o_subtree_size,
    output logic [63:0]        o_subtree_hash,
    output logic               o_is_candidate,
    output logic               o_overflow
);

    localparam logic REG_MIN_SIZE = 1'b0;

    logic [6:0] r_min_size;

    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_SIZE) ? {25'd0, r_min_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= 7'd2;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_SIZE) begin
            r_min_size <= pwdata[6:0];
        end
    end

    psh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_token_code (i_token_code),
        .i_value_bits (i_value_bits),
        .i_position   (i_position),
        .i_expr_id    (i_expr_id),
        .i_new_expr   (i_new_expr),
        .o_job_valid  (fq_valid),
        .i_job_ready  (fq_ready),
        .o_job        (fq_job)
    );

    psh_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_job        (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_job        (qb_job)
    );

    psh_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (qb_valid),
        .o_job_ready    (qb_ready),
        .i_job          (qb_job),
        .i_min_size     (r_min_size),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_expr_id  (o_out_expr_id),
        .o_out_position (o_out_position),
        .o_subtree_size (o_subtree_size),
        .o_subtree_hash (o_subtree_hash),
        .o_is_candidate (o_is_candidate),
        .o_overflow     (o_overflow)
    );

endmodule

>>> tb/tb_prefix_subtree_hasher.sv
// Self-checking testbench for the prefix subtree hasher: expression streams against a predictor.
module tb_prefix_subtree_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] FNV_OFFSET    = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_MULT      = 64'd1099511628211;
    localparam logic [63:0] GOLDEN_K      = 64'h9e3779b97f4a7c15;
    localparam int          TOK_BINARY_MIN = 1;
    localparam int          TOK_UNARY_MIN  = 10;
    localparam int          STACK_DEPTH    = 64;
    localparam int          SIZE_CAP       = 127;
    localparam logic [2:0]  ADDR_MIN_SIZE  = 3'd0;
    localparam int          CYCLE_LIMIT    = 400000;

    typedef enum {ARITY_LEAF, ARITY_UNARY, ARITY_BINARY} t_arity;

    typedef struct packed {
        logic [15:0] expr_id;
        logic [5:0]  position;
        logic [6:0]  size;
        logic [63:0] hash;
        logic        candidate;
        logic        overflow;
    } t_subtree_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_token_code = '0;
    logic [63:0]        i_value_bits = '0;
    logic [5:0]         i_position = '0;
    logic [15:0]        i_expr_id = '0;
    logic               i_new_expr = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [15:0]        o_out_expr_id;
    logic [5:0]         o_out_position;
    logic [6:0]         o_subtree_size;
    logic [63:0]        o_subtree_hash;
    logic               o_is_candidate;
    logic               o_overflow;

    // Predictor state: the stack of open subtrees and the candidate threshold.
    logic [6:0]   subtree_sizes[STACK_DEPTH];
    logic [63:0]  subtree_hashes[STACK_DEPTH];
    int           stack_depth = 0;
    logic [6:0]   min_size_cfg = 7'd2;

    t_subtree_res pending_subtrees[$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    prefix_subtree_hasher uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_token_code   (i_token_code),
        .i_value_bits   (i_value_bits),
        .i_position     (i_position),
        .i_expr_id      (i_expr_id),
        .i_new_expr     (i_new_expr),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_expr_id  (o_out_expr_id),
        .o_out_position (o_out_position),
        .o_subtree_size (o_subtree_size),
        .o_subtree_hash (o_subtree_hash),
        .o_is_candidate (o_is_candidate),
        .o_overflow     (o_overflow)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("prefix_subtree_hasher: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic t_subtree_res predict_subtree(input logic signed [15:0] tok,
            input logic [63:0] vbits, input logic [5:0] pos, input logic [15:0] eid,
            input logic first);
        t_subtree_res r;
        logic [63:0]  h;
        int unsigned  sz;
        int           kids;
        int           k;
        if (first) begin
            stack_depth = 0;
        end
        h = (FNV_OFFSET ^ {{48{tok[15]}}, tok}) * FNV_MULT;
        h = (h ^ vbits) * FNV_MULT;
        kids = (tok < TOK_BINARY_MIN) ? 0 : (tok < TOK_UNARY_MIN) ? 2 : 1;
        sz = 1;
        // Children come off the top of the stack; a missing child is simply skipped.
        for (k = 0; k < kids && stack_depth > 0; k++) begin
            stack_depth--;
            sz += subtree_sizes[stack_depth];
            h = h ^ (subtree_hashes[stack_depth] + GOLDEN_K + (h << 6) + (h >> 2));
        end
        r.overflow = (sz > STACK_DEPTH);
        if (sz > SIZE_CAP) begin
            sz = SIZE_CAP;
        end
        if (stack_depth < STACK_DEPTH) begin
            subtree_sizes[stack_depth] = 7'(sz);
            subtree_hashes[stack_depth] = h;
            stack_depth++;
        end else begin
            r.overflow = 1'b1;
        end
        r.expr_id = eid;
        r.position = pos;
        r.size = 7'(sz);
        r.hash = h;
        r.candidate = (sz >= min_size_cfg);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_subtree_res want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_subtrees.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none got expr %h pos %0d hash %h",
                         $time, o_out_expr_id, o_out_position, o_subtree_hash);
            end else begin
                want = pending_subtrees.pop_back();
                check_field("out_expr_id", want.expr_id, o_out_expr_id);
                check_field("out_position", want.position, o_out_position);
                check_field("subtree_size", want.size, o_subtree_size);
                check_field("subtree_hash", want.hash, o_subtree_hash);
                check_field("is_candidate", want.candidate, o_is_candidate);
                check_field("overflow", want.overflow, o_overflow);
            end
        end
    end

    function automatic logic signed [15:0] rand_token(input t_arity a);
        case (a)
            ARITY_LEAF:   return 16'(-int'($urandom_range(32768, 0)));
            ARITY_UNARY:  return 16'($urandom_range(32767, TOK_UNARY_MIN));
            default:      return 16'($urandom_range(TOK_UNARY_MIN - 1, TOK_BINARY_MIN));
        endcase
    endfunction

    function automatic logic [63:0] rand_bits();
        case ($urandom_range(7))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one item and holds it until accepted; the predictor runs at acceptance.
    task automatic send_tok(input logic signed [15:0] tok, input logic [63:0] vbits,
            input logic [5:0] pos, input logic [15:0] eid, input logic first);
        i_valid <= 1'b1;
        i_token_code <= tok;
        i_value_bits <= vbits;
        i_position <= pos;
        i_expr_id <= eid;
        i_new_expr <= first;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_subtrees.push_front(predict_subtree(tok, vbits, pos, eid, first));
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_subtrees.size() != 0) @(posedge i_clk);
    endtask

    // Writes the threshold once the block is drained, then reads it back.
    task automatic set_min_size(input logic [6:0] value);
        wait_for_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_MIN_SIZE;
        pwdata <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        min_size_cfg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("min size readback", value, prdata[6:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Builds a random prefix expression and sends it last token first; with cut_short it stops before the first tokens.
    task automatic send_expr(input int max_len, input bit with_start, input bit cut_short);
        logic signed [15:0] toks[$];
        logic [15:0]        eid;
        int                 need;
        int                 target;
        int                 last;
        int                 i;
        need = 1;
        target = $urandom_range(max_len, 1);
        eid = 16'($urandom);
        while (need > 0) begin
            if (toks.size() + need >= target || $urandom_range(9) < 3) begin
                toks.insert(toks.size(), rand_token(ARITY_LEAF));
                need--;
            end else if ($urandom_range(2) == 0) begin
                toks.insert(toks.size(), rand_token(ARITY_UNARY));
            end else begin
                toks.insert(toks.size(), rand_token(ARITY_BINARY));
                need++;
            end
        end
        last = cut_short ? $urandom_range(toks.size() - 1, 0) : 0;
        for (i = toks.size() - 1; i >= last; i--) begin
            send_tok(toks[i], rand_bits(), 6'(i), eid, with_start && i == toks.size() - 1);
        end
    endtask

    task automatic test_edge_tokens();
        // A binary node right after new_expr finds no children at all.
        send_tok(16'sd1, 64'd0, 6'd63, 16'hffff, 1'b1);
        send_tok(16'sd32767, '1, 6'd0, 16'h0000, 1'b0);
        send_tok(16'sh8000, '1, 6'd63, 16'h8000, 1'b1);
        send_tok(16'sd0, 64'd0, 6'd62, 16'h8000, 1'b0);
        send_tok(-16'sd1, 64'h8000000000000000, 6'd61, 16'h8000, 1'b0);
        send_tok(16'sd9, 64'h7ff0000000000000, 6'd60, 16'h8000, 1'b0);
        send_tok(16'sd10, 64'h7fffffffffffffff, 6'd59, 16'h8000, 1'b0);
        send_tok(16'sd5, 64'hfff8000000000000, 6'd58, 16'h8000, 1'b0);
        // Without new_expr the next expression folds in what the last one left.
        send_tok(16'sd0, 64'h3ff0000000000000, 6'd3, 16'h1234, 1'b0);
        send_tok(16'sd2, 64'h4000000000000000, 6'd2, 16'h1234, 1'b0);
        send_tok(16'sd11, 64'h0000000000000001, 6'd1, 16'h1234, 1'b0);
        send_tok(16'sd4, 64'haaaaaaaa55555555, 6'd0, 16'h1234, 1'b0);
        send_tok(16'sd100, 64'h5555555555555555, 6'd0, 16'h4321, 1'b1);
        send_tok(16'sd3, 64'h0123456789abcdef, 6'd21, 16'h4321, 1'b0);
        send_tok(16'sh7fff, 64'hfedcba9876543210, 6'd42, 16'h4321, 1'b1);
    endtask

    task automatic test_min_size_settings();
        logic [6:0] settings[4];
        int         n;
        settings = '{7'd0, 7'd127, 7'd1, 7'd64};
        for (n = 0; n < 4; n++) begin
            set_min_size(settings[n]);
            send_expr(8, 1'b1, 1'b0);
            send_expr(8, 1'b1, 1'b0);
        end
        set_min_size(7'd2);
    endtask

    task automatic test_stack_limits();
        int i;
        // Sixty-six leaves in one expression: the last two find the stack full.
        for (i = 0; i < 66; i++) begin
            send_tok(rand_token(ARITY_LEAF), rand_bits(), 6'(65 - i), 16'h00aa, i == 0);
        end
        // Sixty-three binary nodes fold the stack into one subtree of 127 tokens.
        for (i = 0; i < 63; i++) begin
            send_tok(rand_token(ARITY_BINARY), rand_bits(), 6'(i), 16'h00aa, 1'b0);
        end
        // Anything larger saturates the size.
        send_tok(rand_token(ARITY_LEAF), rand_bits(), 6'd5, 16'h00aa, 1'b0);
        send_tok(rand_token(ARITY_BINARY), rand_bits(), 6'd4, 16'h00aa, 1'b0);
        send_tok(rand_token(ARITY_UNARY), rand_bits(), 6'd3, 16'h00aa, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int stop_at;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(19))
                0: begin
                    repeat ($urandom_range(5, 1)) begin
                        send_tok(16'($urandom), rand_bits(), 6'($urandom), 16'($urandom),
                                 $urandom_range(3) == 0);
                    end
                end
                1: send_expr(12, 1'b0, 1'b0);
                2: send_expr(12, 1'b1, 1'b1);
                // The sender holds off until every pending result has come back.
                3: wait_for_results();
                default: send_expr(($urandom_range(9) == 0) ? 63 : 12, 1'b1, 1'b0);
            endcase
        end
        wait_for_results();
    endtask

    initial begin
        send_idle_pct = 27;
        recv_idle_pct = 65;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_tokens();
        test_min_size_settings();
        test_stack_limits();
        test_random_traffic(420, 27, 65);
        set_min_size(7'($urandom_range(127)));
        test_random_traffic(420, 65, 27);
        set_min_size(7'($urandom_range(64, 1)));
        test_random_traffic(420, 0, 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("prefix_subtree_hasher: match");
        end else begin
            $display("prefix_subtree_hasher: mismatch");
        end
        $finish;
    end

endmodule
